@@ hw/rtl/htfc_pkg.sv @@
// Package: constants and CRC-8 helper for the humidity/temperature frame converter.
`default_nettype none

package htfc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned RAW_W    = 16;
    localparam int unsigned RH_W     = 10;
    localparam int unsigned TEMP_W   = 12;

    localparam logic [8:0]  CRC_POLY  = 9'h131;
    localparam logic [10:0] RH_MUL    = 11'd1250;
    localparam logic [10:0] RH_OFFSET = 11'd60;
    localparam logic [10:0] RH_MAX    = 11'd1000;
    localparam logic [14:0] T_MUL     = 15'd17572;
    localparam logic [14:0] T_OFFSET  = 15'd4685;

    // floor(x / 10) == (x * DIV10_MUL) >> DIV10_SHIFT for x below 2^14
    localparam logic [15:0] DIV10_MUL   = 16'd52429;
    localparam int unsigned DIV10_SHIFT = 19;

    // Push one byte through the CRC-8 register, MSB first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int n = 0; n < 8; n++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY[7:0];
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/humidity_temperature_frame_convert.sv @@
// Top level: converts one humidity/temperature sensor frame per beat into scaled readings.
`default_nettype none

// Accepts one frame per clock while the output side does not stall and returns one
// result per frame, in order. The block is a three-register pipeline: an input
// register, a middle register after the two constant multiplications (humidity and
// temperature scaling, CRC-8 check), and a result register after the divide-by-ten of
// the temperature, done as a reciprocal multiplication. Any stage may stall; s_ready
// drops only when all three stages hold a beat and m_ready is low. A CRC mismatch,
// with checking enabled, gives status 1 and zero readings.
module humidity_temperature_frame_convert (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_write_enable,
    input  wire logic                                  cfg_write_data,
    input  wire logic                                  s_valid,
    output logic                                       s_ready,
    input  wire logic [htfc_pkg::BYTE_W-1:0]           s_humidity_high,
    input  wire logic [htfc_pkg::BYTE_W-1:0]           s_humidity_low,
    input  wire logic [htfc_pkg::BYTE_W-1:0]           s_humidity_check,
    input  wire logic [htfc_pkg::BYTE_W-1:0]           s_temperature_high,
    input  wire logic [htfc_pkg::BYTE_W-1:0]           s_temperature_low,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [htfc_pkg::RH_W-1:0]                  m_humidity_tenths,
    output logic signed [htfc_pkg::TEMP_W-1:0]         m_temperature_tenths,
    output logic                                       m_status
);

    logic crc_en_reg;

    // input stage
    logic        in_valid_reg;
    logic [7:0]  in_hh_reg, in_hl_reg, in_hc_reg, in_th_reg, in_tl_reg;

    // middle stage
    logic        mid_valid_reg;
    logic        mid_bad_reg;
    logic [9:0]  mid_rh_reg;
    logic        mid_neg_reg;
    logic [13:0] mid_abs_reg;

    // result stage
    logic        out_valid_reg;
    logic        out_status_reg;
    logic [9:0]  out_rh_reg;
    logic [11:0] out_temp_reg;

    logic adv_out, adv_mid, adv_in;

    assign adv_out = !out_valid_reg || m_ready;
    assign adv_mid = !mid_valid_reg || adv_out;
    assign adv_in  = !in_valid_reg || adv_mid;
    assign s_ready = adv_in;

    // stage one math
    logic [15:0] rh_raw, t_raw;
    logic [7:0]  crc_calc;
    logic        crc_bad_next;
    logic [26:0] rh_prod;
    logic [10:0] rh_scaled, rh_diff;
    logic [9:0]  rh_next;
    logic [30:0] t_prod;
    logic [14:0] t_scaled, t_diff;
    logic        t_neg_next;

    always_comb begin
        rh_raw       = {in_hh_reg, in_hl_reg};
        t_raw        = {in_th_reg, in_tl_reg};
        crc_calc     = htfc_pkg::crc8_byte(htfc_pkg::crc8_byte(8'd0, in_hh_reg), in_hl_reg);
        crc_bad_next = crc_en_reg && (crc_calc != in_hc_reg);

        rh_prod   = {11'd0, rh_raw} * {16'd0, htfc_pkg::RH_MUL};
        rh_scaled = rh_prod[26:16];
        rh_diff   = rh_scaled - htfc_pkg::RH_OFFSET;
        if (rh_scaled < htfc_pkg::RH_OFFSET) begin
            rh_next = '0;
        end else if (rh_diff > htfc_pkg::RH_MAX) begin
            rh_next = htfc_pkg::RH_MAX[9:0];
        end else begin
            rh_next = rh_diff[9:0];
        end

        t_prod     = {15'd0, t_raw} * {16'd0, htfc_pkg::T_MUL};
        t_scaled   = t_prod[30:16];
        t_neg_next = t_scaled < htfc_pkg::T_OFFSET;
        if (t_neg_next) begin
            t_diff = htfc_pkg::T_OFFSET - t_scaled;
        end else begin
            t_diff = t_scaled - htfc_pkg::T_OFFSET;
        end
    end

    // stage two math
    logic [29:0] q_prod;
    logic [10:0] q_mag;
    logic [11:0] temp_next;

    always_comb begin
        q_prod = {16'd0, mid_abs_reg} * {14'd0, htfc_pkg::DIV10_MUL};
        q_mag  = q_prod[29:htfc_pkg::DIV10_SHIFT];
        if (mid_neg_reg) begin
            temp_next = 12'd0 - {1'b0, q_mag};
        end else begin
            temp_next = {1'b0, q_mag};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_en_reg    <= 1'b1;
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_write_enable) begin
                crc_en_reg <= cfg_write_data;
            end
            if (adv_in) begin
                in_valid_reg <= s_valid;
            end
            if (adv_mid) begin
                mid_valid_reg <= in_valid_reg;
            end
            if (adv_out) begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_in) begin
            in_hh_reg <= s_humidity_high;
            in_hl_reg <= s_humidity_low;
            in_hc_reg <= s_humidity_check;
            in_th_reg <= s_temperature_high;
            in_tl_reg <= s_temperature_low;
        end
        if (adv_mid) begin
            mid_bad_reg <= crc_bad_next;
            mid_rh_reg  <= rh_next;
            mid_neg_reg <= t_neg_next;
            mid_abs_reg <= t_diff[13:0];
        end
        if (adv_out) begin
            out_status_reg <= mid_bad_reg;
            out_rh_reg     <= mid_bad_reg ? 10'd0 : mid_rh_reg;
            out_temp_reg   <= mid_bad_reg ? 12'd0 : temp_next;
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_status             = out_status_reg;
    assign m_humidity_tenths    = out_rh_reg;
    assign m_temperature_tenths = signed'(out_temp_reg);

    // a rejected frame carries zero readings
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_humidity_tenths == '0 && m_temperature_tenths == '0)
        else $error("CRC error result carries nonzero readings");

    a_rh_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_humidity_tenths <= htfc_pkg::RH_MAX[9:0])
        else $error("humidity above clamp");

    a_no_check: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !crc_en_reg |-> !m_status)
        else $error("CRC error reported with checking disabled");

    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && mid_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

@@ dv/tb_humidity_temperature_frame_convert.sv @@
// Testbench: streams sensor frames through the frame converter and checks every converted reading.
module tb_humidity_temperature_frame_convert;

    localparam logic [7:0]  CRC_TAPS    = 8'h31;
    localparam int unsigned HUM_SCALE   = 1250;
    localparam int          HUM_BIAS    = 60;
    localparam int          HUM_FULL    = 1000;
    localparam int unsigned TEMP_SCALE  = 17572;
    localparam int          TEMP_BIAS   = 4685;
    localparam int unsigned DRAIN_SLACK = 4;
    localparam int unsigned HOLD_AT     = 150;
    localparam int unsigned HOLD_CYCLES = 64;

    typedef struct packed {
        logic [htfc_pkg::BYTE_W-1:0] humidity_high;
        logic [htfc_pkg::BYTE_W-1:0] humidity_low;
        logic [htfc_pkg::BYTE_W-1:0] humidity_check;
        logic [htfc_pkg::BYTE_W-1:0] temperature_high;
        logic [htfc_pkg::BYTE_W-1:0] temperature_low;
    } frame_t;

    typedef struct packed {
        logic [htfc_pkg::RH_W-1:0]          humidity_tenths;
        logic signed [htfc_pkg::TEMP_W-1:0] temperature_tenths;
        logic                               status;
    } reading_t;

    logic                               aclk                 = 1'b0;
    logic                               aresetn              = 1'b0;
    logic                               cfg_write_enable     = 1'b0;
    logic                               cfg_write_data       = 1'b0;
    logic                               s_valid              = 1'b0;
    logic                               s_ready;
    logic [htfc_pkg::BYTE_W-1:0]        s_humidity_high      = '0;
    logic [htfc_pkg::BYTE_W-1:0]        s_humidity_low       = '0;
    logic [htfc_pkg::BYTE_W-1:0]        s_humidity_check     = '0;
    logic [htfc_pkg::BYTE_W-1:0]        s_temperature_high   = '0;
    logic [htfc_pkg::BYTE_W-1:0]        s_temperature_low    = '0;
    logic                               m_valid;
    logic                               m_ready              = 1'b0;
    logic [htfc_pkg::RH_W-1:0]          m_humidity_tenths;
    logic signed [htfc_pkg::TEMP_W-1:0] m_temperature_tenths;
    logic                               m_status;

    frame_t      frame_q[$];
    reading_t    reading_q[$];
    frame_t      offered;
    reading_t    want;
    reading_t    oldest;
    bit          check_enable   = 1'b1;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    int unsigned send_gap       = 0;
    int unsigned ready_gap      = 0;
    int unsigned hold_left      = 0;
    int unsigned results_seen   = 0;
    int unsigned error_count    = 0;
    int unsigned frames_taken   = 0;
    int unsigned crc_rejects    = 0;
    int unsigned unchecked      = 0;
    int unsigned hum_floor_hits = 0;
    int unsigned hum_ceil_hits  = 0;

    humidity_temperature_frame_convert DUT (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_write_enable     (cfg_write_enable),
        .cfg_write_data       (cfg_write_data),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_humidity_high      (s_humidity_high),
        .s_humidity_low       (s_humidity_low),
        .s_humidity_check     (s_humidity_check),
        .s_temperature_high   (s_temperature_high),
        .s_temperature_low    (s_temperature_low),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_humidity_tenths    (m_humidity_tenths),
        .m_temperature_tenths (m_temperature_tenths),
        .m_status             (m_status)
    );

    always #5 aclk = ~aclk;

    function automatic logic [7:0] humidity_crc(input logic [7:0] hi, input logic [7:0] lo);
        logic [15:0] bits;
        logic [7:0]  c;
        logic        fb;
        bits = {hi, lo};
        c = 8'h00;
        for (int i = 15; i >= 0; i--) begin
            fb = c[7] ^ bits[i];
            c = {c[6:0], 1'b0} ^ (fb ? CRC_TAPS : 8'h00);
        end
        return c;
    endfunction

    function automatic reading_t convert_frame(input frame_t f, input bit check_on);
        int unsigned rh_raw;
        int unsigned t_raw;
        int          rh;
        int          t1;
        int          t_q;
        reading_t    r;
        r = '0;
        if (check_on && humidity_crc(f.humidity_high, f.humidity_low) != f.humidity_check) begin
            r.status = 1'b1;
            return r;
        end
        rh_raw = 32'({f.humidity_high, f.humidity_low});
        rh = int'((rh_raw * HUM_SCALE) >> 16) - HUM_BIAS;
        if (rh < 0) begin
            rh = 0;
        end
        if (rh > HUM_FULL) begin
            rh = HUM_FULL;
        end
        t_raw = 32'({f.temperature_high, f.temperature_low});
        t1 = int'((t_raw * TEMP_SCALE) >> 16) - TEMP_BIAS;
        t_q = t1 / 10;
        r.humidity_tenths    = rh[htfc_pkg::RH_W-1:0];
        r.temperature_tenths = t_q[htfc_pkg::TEMP_W-1:0];
        return r;
    endfunction

    function automatic frame_t make_frame(input logic [15:0] rh_raw, input logic [15:0] t_raw,
                                          input logic [7:0] check_flip);
        frame_t f;
        f.humidity_high    = rh_raw[15:8];
        f.humidity_low     = rh_raw[7:0];
        f.humidity_check   = humidity_crc(rh_raw[15:8], rh_raw[7:0]) ^ check_flip;
        f.temperature_high = t_raw[15:8];
        f.temperature_low  = t_raw[7:0];
        return f;
    endfunction

    function automatic frame_t random_frame();
        logic [15:0] rh;
        logic [15:0] t;
        logic [7:0]  flip;
        int unsigned pick;
        rh = 16'($urandom);
        t = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            rh = 16'($urandom_range(3000, 3300));
        end else if (pick < 20) begin
            rh = 16'($urandom_range(55400, 55800));
        end else if (pick < 30) begin
            t = 16'($urandom_range(17350, 17600));
        end
        flip = ($urandom_range(0, 99) < 20) ? 8'($urandom_range(1, 255)) : 8'h00;
        return make_frame(rh, t, flip);
    endfunction

    function automatic int unsigned pick_gap();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    task automatic write_check_enable(input bit en);
        @(posedge aclk);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= en;
        @(posedge aclk);
        cfg_write_enable <= 1'b0;
        check_enable = en;
    endtask

    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (frame_q.size() != 0 || s_valid || reading_q.size() != 0);
        repeat (DRAIN_SLACK) @(posedge aclk);
    endtask

    // Sender: offer one frame per beat when not idling or stalled, predict at acceptance.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready) begin
                want = convert_frame(offered, check_enable);
                reading_q.push_back(want);
                frames_taken++;
                if (want.status) begin
                    crc_rejects++;
                end else begin
                    if (want.humidity_tenths == 0) begin
                        hum_floor_hits++;
                    end
                    if (want.humidity_tenths == htfc_pkg::RH_W'(HUM_FULL)) begin
                        hum_ceil_hits++;
                    end
                end
                if (!check_enable) begin
                    unchecked++;
                end
            end
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (frame_q.size() != 0) begin
                    offered = frame_q.pop_front();
                    s_humidity_high    <= offered.humidity_high;
                    s_humidity_low     <= offered.humidity_low;
                    s_humidity_check   <= offered.humidity_check;
                    s_temperature_high <= offered.temperature_high;
                    s_temperature_low  <= offered.temperature_low;
                    s_valid            <= 1'b1;
                    send_gap <= ($urandom_range(0, 99) < send_idle_pct) ? pick_gap() : 0;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: compare each result beat, stall at random, hold off once for a long stretch.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (reading_q.size() == 0) begin
                    $error("result beat with no frame outstanding");
                    error_count++;
                end else begin
                    oldest = reading_q.pop_front();
                    if (m_humidity_tenths !== oldest.humidity_tenths) begin
                        $error("humidity_tenths: expected %0d, actual %0d",
                               oldest.humidity_tenths, m_humidity_tenths);
                        error_count++;
                    end
                    if (m_temperature_tenths !== oldest.temperature_tenths) begin
                        $error("temperature_tenths: expected %0d, actual %0d",
                               $signed(oldest.temperature_tenths),
                               $signed(m_temperature_tenths));
                        error_count++;
                    end
                    if (m_status !== oldest.status) begin
                        $error("status: expected %0d, actual %0d", oldest.status, m_status);
                        error_count++;
                    end
                end
                if (results_seen == HOLD_AT) begin
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (ready_gap != 0) begin
                ready_gap--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < recv_idle_pct) begin
                ready_gap = pick_gap() - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // checking on from reset: clamps, zero crossing of temperature, bad check bytes
        send_idle_pct = 30;
        recv_idle_pct = 30;
        frame_q.push_back(make_frame(16'h0000, 16'h0000, 8'h00));
        frame_q.push_back(make_frame(16'hFFFF, 16'hFFFF, 8'h00));
        frame_q.push_back(make_frame(16'd3145, 16'd17473, 8'h00));
        frame_q.push_back(make_frame(16'd3146, 16'd17474, 8'h00));
        frame_q.push_back(make_frame(16'd3199, 16'd17440, 8'h00));
        frame_q.push_back(make_frame(16'd55574, 16'd17436, 8'h00));
        frame_q.push_back(make_frame(16'd55575, 16'd17511, 8'h00));
        frame_q.push_back(make_frame(16'd55700, 16'd17470, 8'h00));
        frame_q.push_back(make_frame(16'hFF00, 16'h00FF, 8'h00));
        frame_q.push_back(make_frame(16'h00FF, 16'hFF00, 8'h00));
        frame_q.push_back(make_frame(16'h8000, 16'h8000, 8'h01));
        frame_q.push_back(make_frame(16'h1234, 16'h5678, 8'h80));
        frame_q.push_back(make_frame(16'h0000, 16'hAAAA, 8'hFF));
        frame_q.push_back(make_frame(16'hFFFF, 16'h5555, 8'hFF));
        wait_drained();

        // checking off: bad check bytes pass through
        write_check_enable(1'b0);
        frame_q.push_back(make_frame(16'h1234, 16'h5678, 8'h5A));
        frame_q.push_back(make_frame(16'hFFFF, 16'hFFFF, 8'h01));
        frame_q.push_back(make_frame(16'h0000, 16'h0000, 8'hFF));
        frame_q.push_back(make_frame(16'h6789, 16'h4321, 8'h00));
        frame_q.push_back(make_frame(16'd3146, 16'd17436, 8'h80));
        wait_drained();

        write_check_enable(1'b1);
        send_idle_pct = 30;
        recv_idle_pct = 30;
        repeat (400) frame_q.push_back(random_frame());
        wait_drained();

        write_check_enable(1'b0);
        send_idle_pct = 20;
        recv_idle_pct = 40;
        repeat (300) frame_q.push_back(random_frame());
        wait_drained();

        write_check_enable(1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (300) frame_q.push_back(random_frame());
        wait_drained();

        write_check_enable(1'b0);
        send_idle_pct = 50;
        recv_idle_pct = 10;
        repeat (250) frame_q.push_back(random_frame());
        wait_drained();

        write_check_enable(1'b1);
        send_idle_pct = 10;
        recv_idle_pct = 50;
        repeat (250) frame_q.push_back(random_frame());
        wait_drained();

        $display("Converted %0d frames (%0d with checking off), %0d rejected on CRC.",
                 frames_taken, unchecked, crc_rejects);
        $display("Humidity held at floor %0d times and at ceiling %0d times; %0d results checked.",
                 hum_floor_hits, hum_ceil_hits, results_seen);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
